### rtl/bb_pkg.sv
// shared types and constants of the edge clipped box blur
// no dependencies
package bb_pkg;

    localparam int CHAN_NUM = 4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_HALF    = 2'd2;
    localparam logic [1:0] CFG_CHANNEL = 2'd3;

    localparam logic [10:0] RST_WIDTH   = 11'd1024;
    localparam logic [10:0] RST_HEIGHT  = 11'd1024;
    localparam logic [1:0]  RST_HALF    = 2'd2;
    localparam logic [2:0]  RST_CHANNEL = 3'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [7:0] chan3;
    } t_in_req;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] mean0;
        logic [7:0] mean1;
        logic [7:0] mean2;
        logic [7:0] mean3;
        logic       frame_end;
    } t_out_req;

    typedef struct packed {
        logic       clr;
        logic       acc;
        logic       step;
        logic [2:0] bit_idx;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_READ,
        S_DRAIN,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### rtl/bb_ram.sv
// generic single write port ram with registered read
// no dependencies
module bb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6151
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bb_lane.sv
// one channel lane: window sum accumulator and bit-serial restoring divider
// depends on bb_pkg
module bb_lane import bb_pkg::*; #(
    parameter int SW = 14,
    parameter int NW = 6
) (
    input  logic          i_clk,
    input  t_lane_ctl     i_ctl,
    input  logic [7:0]    i_sample,
    input  logic [NW-1:0] i_count,
    output logic [7:0]    o_mean
);

    logic [SW-1:0]   r_sum;
    logic [7:0]      r_quot;
    logic [SW+7:0]   w_dv;
    logic            w_ge;

    assign w_dv = (SW + 8)'(i_count) << i_ctl.bit_idx;
    assign w_ge = ({8'b0, r_sum} >= w_dv);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum  <= '0;
            r_quot <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + SW'(i_sample);
        end else if (i_ctl.step) begin
            if (w_ge) begin
                r_sum <= r_sum - SW'(w_dv);
            end
            r_quot[i_ctl.bit_idx] <= w_ge;
        end
    end

    assign o_mean = r_quot;

endmodule

### rtl/edge_clipped_box_blur_top.sv
// edge clipped box blur top: line store, four channel lanes, merge into result
// depends on bb_pkg, bb_ram, bb_lane
// an item with no result returns to idle after a check; one with a result passes
// setup, a read of the n in-frame window pixels (1 to 49), one per cycle from the
// store, a drain, per-lane division and output; one item at a time
// reset: synchronous active low, state, configuration and frame registers to defaults, line store left as is
module edge_clipped_box_blur_top import bb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_HALF   = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int HW = $clog2(MAX_HALF + 1);
    localparam int LW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RD = 2 * MAX_HALF * MAX_WIDTH + 2 * MAX_HALF + 1;
    localparam int AW = $clog2(RD);
    localparam int KS = 2 * MAX_HALF + 1;
    localparam int NW = $clog2(KS * KS + 1);
    localparam int SW = $clog2(KS * KS * 255 + 1);

    t_state r_state, n_state;

    logic [10:0]   r_cfg_w, r_cfg_h;
    logic [1:0]    r_cfg_k;
    logic [2:0]    r_cfg_c;
    logic [CW-1:0] w_w;
    logic [RW-1:0] w_h;
    logic [HW-1:0] w_k;
    logic [2:0]    w_c;
    logic [LW-1:0] r_lag;

    logic [CW-1:0] r_in_col, r_ec, r_c0, r_c1, r_rc;
    logic [RW-1:0] r_in_row, r_er, r_r1, r_rr;
    logic [LW-1:0] r_recv, r_emit_lin;
    logic [AW-1:0] r_wr_addr, r_emit_addr, r_rd_addr, r_row_addr;
    logic          r_done, r_op, r_rd_vld;
    logic [NW-1:0] r_cnt;
    logic [2:0]    r_bit;
    logic          r_out_valid;
    t_out_req      r_out;

    logic          w_in_acc, w_cfg_acc, w_pix, w_out_load;
    logic [CW-1:0] w_bcol, w_ncol;
    logic [RW-1:0] w_brow, w_nrow;
    logic [AW-1:0] w_bwa, w_wa_inc, w_rd_inc, w_row_next, w_emit_inc, w_start;
    logic [LW-1:0] w_brecv;
    logic [31:0]   w_wdata, w_rdata;
    logic [7:0]    w_chan [CHAN_NUM];
    logic [7:0]    w_mean [CHAN_NUM];
    logic [HW-1:0] w_dr, w_dc;
    logic [RW-1:0] w_r0, w_r1;
    logic [CW-1:0] w_cl0, w_cl1;
    logic [RW:0]   w_rsum;
    logic [CW:0]   w_csum;
    logic [CW-1:0] w_necol;
    logic [RW-1:0] w_nerow;
    logic          w_fend;
    t_lane_ctl     w_ctl;
    t_out_req      w_res;

    // clamped configuration
    always_comb begin
        if (r_cfg_w == 11'd0) begin
            w_w = CW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_w = CW'(MAX_WIDTH);
        end else begin
            w_w = CW'(r_cfg_w);
        end
        if (r_cfg_h == 11'd0) begin
            w_h = RW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            w_h = RW'(MAX_HEIGHT);
        end else begin
            w_h = RW'(r_cfg_h);
        end
        if (32'(r_cfg_k) > MAX_HALF) begin
            w_k = HW'(MAX_HALF);
        end else begin
            w_k = HW'(r_cfg_k);
        end
        if (r_cfg_c == 3'd0) begin
            w_c = 3'd1;
        end else if (r_cfg_c > 3'd4) begin
            w_c = 3'd4;
        end else begin
            w_c = r_cfg_c;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_pix       = w_in_acc && (i_in.operation == OP_PIXEL);
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // write side
    assign w_bcol  = r_done ? '0 : r_in_col;
    assign w_brow  = r_done ? '0 : r_in_row;
    assign w_brecv = r_done ? '0 : r_recv;
    assign w_bwa   = r_done ? '0 : r_wr_addr;
    assign w_ncol  = w_bcol + CW'(1);
    assign w_nrow  = w_brow + RW'(1);

    assign w_chan[0] = i_in.chan0;
    assign w_chan[1] = i_in.chan1;
    assign w_chan[2] = i_in.chan2;
    assign w_chan[3] = i_in.chan3;

    always_comb begin
        for (int k = 0; k < CHAN_NUM; k++) begin
            w_wdata[8*k +: 8] = (3'(k) < w_c) ? w_chan[k] : 8'd0;
        end
    end

    // ring address steps
    always_comb begin
        int a, b, c, d, e;
        a = int'(w_bwa) + 1;
        b = int'(r_rd_addr) + 1;
        c = int'(r_row_addr) + int'(w_w);
        d = int'(r_emit_addr) + 1;
        e = int'(w_dr) * int'(w_w) + int'(w_dc);
        if (a >= RD) a = a - RD;
        if (b >= RD) b = b - RD;
        if (c >= RD) c = c - RD;
        if (d >= RD) d = d - RD;
        if (int'(r_emit_addr) >= e) begin
            e = int'(r_emit_addr) - e;
        end else begin
            e = int'(r_emit_addr) + RD - e;
        end
        w_wa_inc   = AW'(a);
        w_rd_inc   = AW'(b);
        w_row_next = AW'(c);
        w_emit_inc = AW'(d);
        w_start    = AW'(e);
    end

    // window bounds
    assign w_dr   = (r_er >= RW'(w_k)) ? w_k : HW'(r_er);
    assign w_dc   = (r_ec >= CW'(w_k)) ? w_k : HW'(r_ec);
    assign w_r0   = r_er - RW'(w_dr);
    assign w_cl0  = r_ec - CW'(w_dc);
    assign w_rsum = {1'b0, r_er} + (RW + 1)'(w_k);
    assign w_csum = {1'b0, r_ec} + (CW + 1)'(w_k);
    assign w_r1   = (w_rsum < {1'b0, w_h}) ? RW'(w_rsum) : w_h - RW'(1);
    assign w_cl1  = (w_csum < {1'b0, w_w}) ? CW'(w_csum) : w_w - CW'(1);

    bb_ram #(
        .WIDTH (32),
        .DEPTH (RD)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_pix),
        .i_waddr (w_bwa),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_ctl.clr     = (r_state == S_SETUP);
    assign w_ctl.acc     = r_rd_vld;
    assign w_ctl.step    = (r_state == S_DIV);
    assign w_ctl.bit_idx = r_bit;

    for (genvar g = 0; g < CHAN_NUM; g++) begin : g_lane
        bb_lane #(
            .SW (SW),
            .NW (NW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_sample (w_rdata[8*g +: 8]),
            .i_count  (r_cnt),
            .o_mean   (w_mean[g])
        );
    end

    // merge lanes into the result
    assign w_necol = (r_ec + CW'(1) == w_w) ? '0 : r_ec + CW'(1);
    assign w_nerow = (r_ec + CW'(1) == w_w) ? r_er + RW'(1) : r_er;
    assign w_fend  = (w_nerow == w_h);

    always_comb begin
        w_res.out_row   = 10'(r_er);
        w_res.out_col   = 10'(r_ec);
        w_res.mean0     = w_mean[0];
        w_res.mean1     = (w_c > 3'd1) ? w_mean[1] : 8'd0;
        w_res.mean2     = (w_c > 3'd2) ? w_mean[2] : 8'd0;
        w_res.mean3     = (w_c > 3'd3) ? w_mean[3] : 8'd0;
        w_res.frame_end = w_fend;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_op == OP_FLUSH) begin
                    n_state = r_done ? S_SETUP : S_IDLE;
                end else begin
                    n_state = ((r_recv - r_emit_lin) > r_lag) ? S_SETUP : S_IDLE;
                end
            end
            S_SETUP: n_state = S_READ;
            S_READ: begin
                if (r_rc == r_c1 && r_rr == r_r1) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DIV;
            S_DIV: begin
                if (r_bit == 3'd0) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lag    <= LW'(int'(w_k) * int'(w_w) + int'(w_k));
        r_rd_vld <= (r_state == S_READ);
        if (w_in_acc) r_op <= i_in.operation;
        if (!i_rst_n) begin
            r_cfg_w     <= RST_WIDTH;
            r_cfg_h     <= RST_HEIGHT;
            r_cfg_k     <= RST_HALF;
            r_cfg_c     <= RST_CHANNEL;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_recv      <= '0;
            r_wr_addr   <= '0;
            r_ec        <= '0;
            r_er        <= '0;
            r_emit_lin  <= '0;
            r_emit_addr <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
        end else begin
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:   r_cfg_w <= i_cfg_data;
                    CFG_HEIGHT:  r_cfg_h <= i_cfg_data;
                    CFG_HALF:    r_cfg_k <= i_cfg_data[1:0];
                    CFG_CHANNEL: r_cfg_c <= i_cfg_data[2:0];
                endcase
                r_in_col    <= '0;
                r_in_row    <= '0;
                r_recv      <= '0;
                r_wr_addr   <= '0;
                r_ec        <= '0;
                r_er        <= '0;
                r_emit_lin  <= '0;
                r_emit_addr <= '0;
                r_done      <= 1'b0;
            end else if (w_pix) begin
                // a pixel after frame end starts a new frame
                if (r_done) begin
                    r_ec        <= '0;
                    r_er        <= '0;
                    r_emit_lin  <= '0;
                    r_emit_addr <= '0;
                end
                r_recv    <= w_brecv + LW'(1);
                r_wr_addr <= w_wa_inc;
                if (w_ncol == w_w) begin
                    r_in_col <= '0;
                    if (w_nrow == w_h) begin
                        r_in_row <= '0;
                        r_done   <= 1'b1;
                    end else begin
                        r_in_row <= w_nrow;
                        r_done   <= 1'b0;
                    end
                end else begin
                    r_in_col <= w_ncol;
                    r_in_row <= w_brow;
                    r_done   <= 1'b0;
                end
            end else if (w_out_load) begin
                r_out_valid <= 1'b1;
                if (w_fend) begin
                    r_in_col    <= '0;
                    r_in_row    <= '0;
                    r_recv      <= '0;
                    r_wr_addr   <= '0;
                    r_ec        <= '0;
                    r_er        <= '0;
                    r_emit_lin  <= '0;
                    r_emit_addr <= '0;
                    r_done      <= 1'b0;
                end else begin
                    r_ec        <= w_necol;
                    r_er        <= w_nerow;
                    r_emit_lin  <= r_emit_lin + LW'(1);
                    r_emit_addr <= w_emit_inc;
                end
            end
            if (r_state == S_DRAIN) begin
                r_bit <= 3'd7;
            end else if (r_state == S_DIV) begin
                r_bit <= r_bit - 3'd1;
            end
        end
    end

    // window read sequencer and result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) r_out <= w_res;
        if (r_state == S_SETUP) begin
            r_rr       <= w_r0;
            r_r1       <= w_r1;
            r_rc       <= w_cl0;
            r_c0       <= w_cl0;
            r_c1       <= w_cl1;
            r_rd_addr  <= w_start;
            r_row_addr <= w_start;
            r_cnt      <= '0;
        end else if (r_state == S_READ) begin
            r_cnt <= r_cnt + NW'(1);
            if (r_rc == r_c1) begin
                r_rc       <= r_c0;
                r_rr       <= r_rr + RW'(1);
                r_rd_addr  <= w_row_next;
                r_row_addr <= w_row_next;
            end else begin
                r_rc      <= r_rc + CW'(1);
                r_rd_addr <= w_rd_inc;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
